// ===== hw/rtl/dirty_tracked_char_frame_buffer_core_assert.svh =====
// Assertion macros shared by the frame buffer RTL.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef DIRTY_TRACKED_CHAR_FRAME_BUFFER_CORE_ASSERT_SVH
`define DIRTY_TRACKED_CHAR_FRAME_BUFFER_CORE_ASSERT_SVH

// antecedent in the same cycle implies consequent
`define DTCFB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define DTCFB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dtcfb_pkg.sv =====
`default_nettype none
package dtcfb_pkg;

   // field widths
   localparam int FUNC_W      = 2;
   localparam int POS_W       = 10;
   localparam int CHAR_W      = 8;
   localparam int COLOR_W     = 16;
   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int CELL_X_W    = 6;
   localparam int CELL_Y_W    = 8;
   localparam int WIDTH_REG_W = 7;
   localparam int HEIGHT_REG_W = 9;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // stored word: {changed, color, char}
   localparam int WORD_W = 1 + COLOR_W + CHAR_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_DRAW  = 2'd0,
      FUNC_CLEAR = 2'd1,
      FUNC_FORCE = 2'd2,
      FUNC_FLUSH = 2'd3
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DRAW = 2'd0,
      KIND_CELL = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BG_CHAR  = 3'd0,
      CSR_BG_COLOR = 3'd1,
      CSR_WIDTH    = 3'd2,
      CSR_HEIGHT   = 3'd3,
      CSR_MUTE     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   localparam logic [CHAR_W-1:0]       BG_CHAR_RESET  = 8'd32;
   localparam logic [COLOR_W-1:0]      BG_COLOR_RESET = 16'h0000;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET    = 7'd64;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET   = 9'd64;

endpackage
`default_nettype wire

// ===== hw/rtl/dirty_tracked_char_frame_buffer_core.sv =====
`default_nettype none
// Character-cell frame buffer with per-cell changed marks. Issue a command by
// holding start high with the req_ fields while busy is low; the command is
// taken at that edge. Results come back as one-cycle strobes on rsp_valid and
// cannot be stalled, so the receiver must take every beat as it appears.
// A draw's status beat follows on the next cycle; busy stays low, so draws
// can be issued every cycle. A clear or forced clear walks every cell in use
// through the cell memory, one cell per cycle (one read port, one write
// port), and keeps busy high throughout; its acknowledge beat appears in the
// first cycle after busy falls. A row flush walks one row with busy high;
// changed cells stream out unless muted, as they are found (one cell behind);
// the final beat, carrying rsp_last, likewise lands in the first cycle after
// busy falls. A flush or clear that covers no cell answers on the next cycle
// without going busy. After reset the block sweeps the changed marks clear
// over every cell with busy high; configuration writes are taken at any time
// (csr_ready is tied high) but must only be issued while no command is in
// progress. Software should run a forced clear before first use.
module dirty_tracked_char_frame_buffer_core #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  wire  logic                               clock,
   input  wire  logic                               reset,
   // command channel
   input  wire  logic                               start,
   output logic                                     busy,
   input  wire  logic [dtcfb_pkg::FUNC_W-1:0]       req_func,
   input  wire  logic [dtcfb_pkg::POS_W-1:0]        req_pos_x,
   input  wire  logic [dtcfb_pkg::POS_W-1:0]        req_pos_y,
   input  wire  logic [dtcfb_pkg::CHAR_W-1:0]       req_glyph,
   input  wire  logic [dtcfb_pkg::COLOR_W-1:0]      req_color_word,
   // result channel
   output logic                                     rsp_valid,
   output logic [dtcfb_pkg::KIND_W-1:0]             rsp_kind,
   output logic                                     rsp_status,
   output logic [dtcfb_pkg::CELL_X_W-1:0]           rsp_cell_x,
   output logic [dtcfb_pkg::CELL_Y_W-1:0]           rsp_cell_y,
   output logic [dtcfb_pkg::CHAR_W-1:0]             rsp_cell_char,
   output logic [dtcfb_pkg::BYTE_W-1:0]             rsp_fg_color,
   output logic [dtcfb_pkg::BYTE_W-1:0]             rsp_bg_color,
   output logic                                     rsp_last,
   // configuration channel
   input  wire  logic                               csr_valid,
   output logic                                     csr_ready,
   input  wire  logic [dtcfb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  logic [dtcfb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dtcfb_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam logic [WIDTH_REG_W-1:0]  MAX_COLS_REG = WIDTH_REG_W'(MAX_COLS);
   localparam logic [HEIGHT_REG_W-1:0] MAX_ROWS_REG = HEIGHT_REG_W'(MAX_ROWS);
   localparam logic [AW-1:0]           LAST_ADDR    = AW'(DEPTH - 1);
   localparam logic [AW-1:0]           ROW_STEP     = AW'(MAX_COLS);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [CHAR_W-1:0]       bg_char_ff;
   logic [COLOR_W-1:0]      bg_color_ff;
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic                    mute_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_char_ff  <= BG_CHAR_RESET;
         bg_color_ff <= BG_COLOR_RESET;
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         mute_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_BG_CHAR:  bg_char_ff  <= csr_wdata[CHAR_W-1:0];
            CSR_BG_COLOR: bg_color_ff <= csr_wdata[COLOR_W-1:0];
            CSR_WIDTH:    width_ff    <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_HEIGHT:   height_ff   <= csr_wdata[HEIGHT_REG_W-1:0];
            CSR_MUTE:     mute_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // area in use, saturated at the buffer size
   logic [CW-1:0] cols_eff;
   logic [RW-1:0] rows_eff;
   assign cols_eff = CW'((width_ff > MAX_COLS_REG) ? MAX_COLS_REG : width_ff);
   assign rows_eff = RW'((height_ff > MAX_ROWS_REG) ? MAX_ROWS_REG : height_ff);

   // ------------------------------------------------------------------
   // command decode
   // ------------------------------------------------------------------
   logic accept;
   logic x_in_area, y_in_area, draw_ok;
   logic clear_go, flush_go;
   logic [AW-1:0] draw_addr, flush_base;

   assign accept    = start && !busy;
   assign x_in_area = !req_pos_x[POS_W-1] &&
                      (req_pos_x[POS_W-2:0] < (POS_W-1)'(cols_eff));
   assign y_in_area = !req_pos_y[POS_W-1] &&
                      (req_pos_y[POS_W-2:0] < (POS_W-1)'(rows_eff));
   assign draw_ok   = x_in_area && y_in_area;
   assign clear_go  = (cols_eff != '0) && (rows_eff != '0);
   assign flush_go  = y_in_area && (cols_eff != '0);
   assign flush_base = AW'(32'(req_pos_y[POS_W-2:0]) * MAX_COLS);
   assign draw_addr  = AW'(32'(req_pos_y[POS_W-2:0]) * MAX_COLS +
                           32'(req_pos_x[POS_W-2:0]));

   // ------------------------------------------------------------------
   // cell memory: {changed, color, char}, one read and one write port
   // ------------------------------------------------------------------
   logic [WORD_W-1:0] cell_mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   // ------------------------------------------------------------------
   // control and datapath registers
   // ------------------------------------------------------------------
   state_type     state_ff, state_in;
   logic [AW-1:0] init_addr_ff, init_addr_in;
   logic          issue_on_ff, issue_on_in;
   logic          op_flush_ff, op_flush_in;
   logic          op_force_ff, op_force_in;
   logic [XW-1:0] scan_x_ff, scan_x_in;
   logic [YW-1:0] scan_y_ff, scan_y_in;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic [AW-1:0] row_base_ff, row_base_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_last_ff, s1_last_in;
   logic [XW-1:0] s1_x_ff, s1_x_in;
   logic [YW-1:0] s1_y_ff, s1_y_in;
   logic [AW-1:0] s1_addr_ff, s1_addr_in;
   // flush holds one found cell back so the final one can carry last
   logic                pend_valid_ff, pend_valid_in;
   logic [XW-1:0]       pend_x_ff, pend_x_in;
   logic [YW-1:0]       pend_y_ff, pend_y_in;
   logic [CHAR_W-1:0]   pend_char_ff, pend_char_in;
   logic [COLOR_W-1:0]  pend_color_ff, pend_color_in;
   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [CELL_X_W-1:0] rsp_x_ff, rsp_x_in;
   logic [CELL_Y_W-1:0] rsp_y_ff, rsp_y_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic                rsp_last_ff, rsp_last_in;

   // fields of the word read for the cell in stage 1
   logic [CHAR_W-1:0]  s1_char;
   logic [COLOR_W-1:0] s1_color;
   logic               s1_changed;
   logic               s1_match;
   logic               x_at_end, y_at_end;

   assign s1_char    = rd_data_ff[CHAR_W-1:0];
   assign s1_color   = rd_data_ff[CHAR_W +: COLOR_W];
   assign s1_changed = rd_data_ff[WORD_W-1];
   assign s1_match   = !op_force_ff && (s1_char == bg_char_ff) &&
                       (s1_color == bg_color_ff);
   assign x_at_end   = (scan_x_ff == XW'(cols_eff - CW'(1)));
   assign y_at_end   = (scan_y_ff == YW'(rows_eff - RW'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (init_addr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (func_type'(req_func))
                  FUNC_CLEAR, FUNC_FORCE: if (clear_go) state_in = ST_SCAN;
                  FUNC_FLUSH:             if (flush_go) state_in = ST_SCAN;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (s1_valid_ff && s1_last_ff) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      init_addr_in  = init_addr_ff;
      issue_on_in   = issue_on_ff;
      op_flush_in   = op_flush_ff;
      op_force_in   = op_force_ff;
      scan_x_in     = scan_x_ff;
      scan_y_in     = scan_y_ff;
      scan_addr_in  = scan_addr_ff;
      row_base_in   = row_base_ff;
      s1_valid_in   = 1'b0;
      s1_last_in    = 1'b0;
      s1_x_in       = scan_x_ff;
      s1_y_in       = scan_y_ff;
      s1_addr_in    = scan_addr_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_char_in  = pend_char_ff;
      pend_color_in = pend_color_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_DRAW;
      rsp_status_in = STATUS_OK;
      rsp_x_in      = '0;
      rsp_y_in      = '0;
      rsp_char_in   = '0;
      rsp_color_in  = '0;
      rsp_last_in   = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = s1_addr_ff;
      mem_wdata     = '0;

      case (state_ff)
         ST_INIT: begin
            // sweep the changed marks clear
            mem_we       = 1'b1;
            mem_waddr    = init_addr_ff;
            mem_wdata    = '0;
            init_addr_in = init_addr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               pend_valid_in = 1'b0;
               op_flush_in   = (func_type'(req_func) == FUNC_FLUSH);
               op_force_in   = (func_type'(req_func) == FUNC_FORCE);
               case (func_type'(req_func))
                  FUNC_DRAW: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_DRAW;
                     rsp_last_in  = 1'b1;
                     if (draw_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = draw_addr;
                        mem_wdata = {1'b1, req_color_word, req_glyph};
                     end else begin
                        rsp_status_in = STATUS_BAD;
                     end
                  end
                  FUNC_CLEAR, FUNC_FORCE: begin
                     if (clear_go) begin
                        issue_on_in  = 1'b1;
                        scan_x_in    = '0;
                        scan_y_in    = '0;
                        scan_addr_in = '0;
                        row_base_in  = '0;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_END;
                        rsp_last_in  = 1'b1;
                     end
                  end
                  FUNC_FLUSH: begin
                     if (flush_go) begin
                        issue_on_in  = 1'b1;
                        scan_x_in    = '0;
                        scan_y_in    = YW'(req_pos_y[POS_W-2:0]);
                        scan_addr_in = flush_base;
                        row_base_in  = flush_base;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_END;
                        rsp_last_in  = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // read side: issue one cell per cycle
            if (issue_on_ff) begin
               s1_valid_in = 1'b1;
               if (x_at_end && (op_flush_ff || y_at_end)) begin
                  s1_last_in  = 1'b1;
                  issue_on_in = 1'b0;
               end else if (x_at_end) begin
                  scan_x_in    = '0;
                  scan_y_in    = scan_y_ff + YW'(1);
                  row_base_in  = row_base_ff + ROW_STEP;
                  scan_addr_in = row_base_ff + ROW_STEP;
               end else begin
                  scan_x_in    = scan_x_ff + XW'(1);
                  scan_addr_in = scan_addr_ff + AW'(1);
               end
            end
            // write side: modify and write back the cell read last cycle
            if (s1_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = s1_addr_ff;
               if (op_flush_ff) begin
                  mem_wdata = {1'b0, s1_color, s1_char};
                  if (s1_changed && !mute_ff) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_CELL;
                        rsp_x_in     = CELL_X_W'(pend_x_ff);
                        rsp_y_in     = CELL_Y_W'(pend_y_ff);
                        rsp_char_in  = pend_char_ff;
                        rsp_color_in = pend_color_ff;
                     end
                     pend_valid_in = 1'b1;
                     pend_x_in     = s1_x_ff;
                     pend_y_in     = s1_y_ff;
                     pend_char_in  = s1_char;
                     pend_color_in = s1_color;
                  end
               end else if (s1_match) begin
                  mem_wdata = {1'b0, s1_color, s1_char};
               end else begin
                  mem_wdata = {1'b1, bg_color_ff, bg_char_ff};
               end
            end
         end
         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            pend_valid_in = 1'b0;
            if (op_flush_ff && pend_valid_ff) begin
               rsp_kind_in  = KIND_CELL;
               rsp_x_in     = CELL_X_W'(pend_x_ff);
               rsp_y_in     = CELL_Y_W'(pend_y_ff);
               rsp_char_in  = pend_char_ff;
               rsp_color_in = pend_color_ff;
            end else begin
               rsp_kind_in = KIND_END;
            end
         end
         default: ;
      endcase
   end

   // memory
   always_ff @(posedge clock) begin
      if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= cell_mem[scan_addr_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         init_addr_ff  <= '0;
         issue_on_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_addr_ff  <= init_addr_in;
         issue_on_ff   <= issue_on_in;
         s1_valid_ff   <= s1_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_flush_ff   <= op_flush_in;
      op_force_ff   <= op_force_in;
      scan_x_ff     <= scan_x_in;
      scan_y_ff     <= scan_y_in;
      scan_addr_ff  <= scan_addr_in;
      row_base_ff   <= row_base_in;
      s1_last_ff    <= s1_last_in;
      s1_x_ff       <= s1_x_in;
      s1_y_ff       <= s1_y_in;
      s1_addr_ff    <= s1_addr_in;
      pend_x_ff     <= pend_x_in;
      pend_y_ff     <= pend_y_in;
      pend_char_ff  <= pend_char_in;
      pend_color_ff <= pend_color_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_cell_x    = rsp_x_ff;
   assign rsp_cell_y    = rsp_y_ff;
   assign rsp_cell_char = rsp_char_ff;
   assign rsp_fg_color  = rsp_color_ff[BYTE_W-1:0];
   assign rsp_bg_color  = rsp_color_ff[COLOR_W-1:BYTE_W];
   assign rsp_last      = rsp_last_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
`include "dirty_tracked_char_frame_buffer_core_assert.svh"

   // a draw always answers with its status beat on the next cycle
   `DTCFB_ASSERT_NEXT(a_draw_answers, accept && (req_func == FUNC_DRAW), rsp_valid && (rsp_kind == KIND_DRAW) && rsp_last, "draw beat missing")
   // the closing cycle of a walk always delivers the final beat and frees the block
   `DTCFB_ASSERT_NEXT(a_finish_last, state_ff == ST_FINISH, rsp_valid && rsp_last && !busy, "walk ended without final beat")
   // the write-back stage only runs inside a walk
   `DTCFB_ASSERT_SAME(a_s1_in_scan, s1_valid_ff, state_ff == ST_SCAN, "write-back outside walk")
   // no result beats during the reset sweep
   `DTCFB_ASSERT_SAME(a_quiet_init, state_ff == ST_INIT, !rsp_valid_ff, "beat during reset sweep")

endmodule
`default_nettype wire

// ===== test/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dtcfb_pkg::*;

   // Geometry of the instance under test; the cell index is y * FB_COLS + x.
   localparam int FB_COLS  = 64;
   localparam int FB_ROWS  = 64;
   localparam int FB_CELLS = FB_COLS * FB_ROWS;

   // Longest quiet spell is a full-size clear or the mark sweep after reset,
   // each walking all FB_CELLS cells; the watchdog allows several times that.
   localparam int QUIET_LIMIT   = 20000;
   // Pause after the last beat before touching the registers.
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASES        = 7;

   // One result beat, in port order.
   typedef struct packed {
      kind_type                kind;
      logic                    status;
      logic [CELL_X_W-1:0]     x;
      logic [CELL_Y_W-1:0]     y;
      logic [CHAR_W-1:0]       glyph;
      logic [BYTE_W-1:0]       fg;
      logic [BYTE_W-1:0]       bg;
      logic                    last;
   } fb_beat_t;

   // One row of the directed script: a register write or a command, the
   // latter optionally with its single beat written out by hand.
   typedef struct {
      logic                    is_write;
      csr_index_type           idx;
      logic [CSR_DATA_W-1:0]   wdata;
      func_type                func;
      logic [POS_W-1:0]        px;
      logic [POS_W-1:0]        py;
      logic [CHAR_W-1:0]       glyph;
      logic [COLOR_W-1:0]      color;
      logic                    fixed;
      fb_beat_t                want;
   } script_row_t;

   // ---------------------------------------------------------------- DUT I/O
   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    start          = 1'b0;
   logic                    busy;
   logic [FUNC_W-1:0]       req_func       = '0;
   logic [POS_W-1:0]        req_pos_x      = '0;
   logic [POS_W-1:0]        req_pos_y      = '0;
   logic [CHAR_W-1:0]       req_glyph      = '0;
   logic [COLOR_W-1:0]      req_color_word = '0;
   logic                    rsp_valid;
   logic [KIND_W-1:0]       rsp_kind;
   logic                    rsp_status;
   logic [CELL_X_W-1:0]     rsp_cell_x;
   logic [CELL_Y_W-1:0]     rsp_cell_y;
   logic [CHAR_W-1:0]       rsp_cell_char;
   logic [BYTE_W-1:0]       rsp_fg_color;
   logic [BYTE_W-1:0]       rsp_bg_color;
   logic                    rsp_last;
   logic                    csr_valid      = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index      = CSR_BG_CHAR;
   logic [CSR_DATA_W-1:0]   csr_wdata      = '0;

   always #5ns clock = ~clock;

   dirty_tracked_char_frame_buffer_core #(
      .MAX_COLS (FB_COLS),
      .MAX_ROWS (FB_ROWS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_glyph      (req_glyph),
      .req_color_word (req_color_word),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_status     (rsp_status),
      .rsp_cell_x     (rsp_cell_x),
      .rsp_cell_y     (rsp_cell_y),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_fg_color   (rsp_fg_color),
      .rsp_bg_color   (rsp_bg_color),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // ------------------------------------------------------- frame buffer copy
   // Shadow of the cell memories and of the registers, updated when a
   // command or a register write is taken.
   logic [CHAR_W-1:0]       glyph_mem [FB_CELLS];
   logic [COLOR_W-1:0]      color_mem [FB_CELLS];
   logic                    dirty_mem [FB_CELLS];
   logic [CHAR_W-1:0]       cfg_bg_char  = BG_CHAR_RESET;
   logic [COLOR_W-1:0]      cfg_bg_color = BG_COLOR_RESET;
   logic [WIDTH_REG_W-1:0]  cfg_width    = WIDTH_RESET;
   logic [HEIGHT_REG_W-1:0] cfg_height   = HEIGHT_RESET;
   logic                    cfg_mute     = 1'b0;

   fb_beat_t pending_beats [$];   // beats still owed by the DUT, oldest first
   fb_beat_t cmd_beats [$];       // beats of the command just taken
   int       fail_count = 0;

   // The reset sweep clears every changed mark.
   initial foreach (dirty_mem[i]) dirty_mem[i] = 1'b0;

   function automatic fb_beat_t make_beat(kind_type k, logic st, int x, int y,
                                          logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] col,
                                          logic last);
      fb_beat_t b;
      b.kind   = k;
      b.status = st;
      b.x      = CELL_X_W'(x);
      b.y      = CELL_Y_W'(y);
      b.glyph  = ch;
      b.fg     = col[7:0];
      b.bg     = col[15:8];
      b.last   = last;
      return b;
   endfunction

   // Size registers saturate at the memory geometry.
   function automatic int cols_in_use();
      return (int'(cfg_width) > FB_COLS) ? FB_COLS : int'(cfg_width);
   endfunction

   function automatic int rows_in_use();
      return (int'(cfg_height) > FB_ROWS) ? FB_ROWS : int'(cfg_height);
   endfunction

   function automatic void apply_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_BG_CHAR:  cfg_bg_char  = d[CHAR_W-1:0];
         CSR_BG_COLOR: cfg_bg_color = d[COLOR_W-1:0];
         CSR_WIDTH:    cfg_width    = d[WIDTH_REG_W-1:0];
         CSR_HEIGHT:   cfg_height   = d[HEIGHT_REG_W-1:0];
         CSR_MUTE:     cfg_mute     = d[0];
         default: ;
      endcase
   endfunction

   // Runs one command on the shadow and leaves its beats in cmd_beats.
   function automatic void predict_fb_beats(func_type f, logic [POS_W-1:0] px,
                                            logic [POS_W-1:0] py, logic [CHAR_W-1:0] g,
                                            logic [COLOR_W-1:0] c);
      int cols, rows, sx, sy, x, y, i;
      cols = cols_in_use();
      rows = rows_in_use();
      sx   = $signed(px);
      sy   = $signed(py);
      cmd_beats.delete();
      case (f)
         FUNC_DRAW: begin
            if (sx < 0 || sy < 0 || sx >= cols || sy >= rows) begin
               cmd_beats.push_back(make_beat(KIND_DRAW, STATUS_BAD, 0, 0, '0, '0, 1'b1));
            end else begin
               i = sy * FB_COLS + sx;
               glyph_mem[i] = g;
               color_mem[i] = c;
               dirty_mem[i] = 1'b1;
               cmd_beats.push_back(make_beat(KIND_DRAW, STATUS_OK, 0, 0, '0, '0, 1'b1));
            end
         end
         FUNC_CLEAR, FUNC_FORCE: begin
            // plain clear unmarks cells already at background
            for (y = 0; y < rows; y++) begin
               for (x = 0; x < cols; x++) begin
                  i = y * FB_COLS + x;
                  if (f == FUNC_CLEAR && glyph_mem[i] == cfg_bg_char &&
                      color_mem[i] == cfg_bg_color) begin
                     dirty_mem[i] = 1'b0;
                  end else begin
                     glyph_mem[i] = cfg_bg_char;
                     color_mem[i] = cfg_bg_color;
                     dirty_mem[i] = 1'b1;
                  end
               end
            end
            cmd_beats.push_back(make_beat(KIND_END, STATUS_OK, 0, 0, '0, '0, 1'b1));
         end
         default: begin
            // row flush: marks go away even when muted
            if (sy >= 0 && sy < rows) begin
               for (x = 0; x < cols; x++) begin
                  i = sy * FB_COLS + x;
                  if (dirty_mem[i] && !cfg_mute)
                     cmd_beats.push_back(make_beat(KIND_CELL, STATUS_OK, x, sy,
                                                   glyph_mem[i], color_mem[i], 1'b0));
                  dirty_mem[i] = 1'b0;
               end
            end
            if (cmd_beats.size() == 0)
               cmd_beats.push_back(make_beat(KIND_END, STATUS_OK, 0, 0, '0, '0, 1'b1));
            else
               cmd_beats[cmd_beats.size()-1].last = 1'b1;
         end
      endcase
   endfunction

   // ------------------------------------------------------------- result side
   function automatic string beat_text(fb_beat_t b);
      return $sformatf("kind=%0d status=%0d x=%0d y=%0d char=%02h fg=%02h bg=%02h last=%0d",
                       b.kind, b.status, b.x, b.y, b.glyph, b.fg, b.bg, b.last);
   endfunction

   // Results cannot be stalled: every strobe is a beat.
   always @(posedge clock) begin
      fb_beat_t got, want;
      if (!reset && rsp_valid === 1'b1) begin
         got = {rsp_kind, rsp_status, rsp_cell_x, rsp_cell_y, rsp_cell_char,
                rsp_fg_color, rsp_bg_color, rsp_last};
         if (pending_beats.size() == 0) begin
            fail_count++;
            if (fail_count <= 50)
               $display("%0t: beat with nothing expected, actual %s", $time, beat_text(got));
         end else begin
            want = pending_beats.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 50)
                  $display("%0t: beat mismatch, expected %s, actual %s",
                           $time, beat_text(want), beat_text(got));
            end
         end
      end
   end

   // Watchdog: any accepted command, beat or register write resets it.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1 || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // ------------------------------------------------------------- drive side
   bit start_high = 0;   // start was raised and not yet lowered
   bit csr_high   = 0;   // csr_valid was raised and not yet lowered
   bit idling_on  = 1;

   // Each lowers a strobe only once, so no step gets two assignments.
   task automatic quiet();
      if (start_high) begin
         start <= 1'b0;
         start_high = 0;
      end
      if (csr_high) begin
         csr_valid <= 1'b0;
         csr_high = 0;
      end
   endtask

   // Wait until every owed beat is in and the block is idle. Checked on the
   // falling edge so the monitor's pops at the rising edge are settled.
   task automatic drain();
      quiet();
      while (pending_beats.size() != 0 || busy !== 1'b0) @(negedge clock);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random sender gaps; a gap goes on with a chance of 31 in 100 at each step.
   task automatic sender_gap();
      if (idling_on) begin
         while ($urandom_range(0, 99) < 31) begin
            quiet();
            @(posedge clock);
         end
      end
   endtask

   // Registers change only with the block idle; back-to-back writes keep
   // csr_valid high.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] d);
      if (!csr_high) drain();
      csr_valid <= 1'b1;
      csr_high = 1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      apply_reg(idx, d);
   endtask

   // Hold start until taken (start high, busy low at the edge), then queue
   // the beats: the hand-written one where given, else the prediction.
   task automatic issue_command(func_type f, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                logic [CHAR_W-1:0] g, logic [COLOR_W-1:0] c,
                                logic fixed, fb_beat_t want);
      if (csr_high) begin
         csr_valid <= 1'b0;
         csr_high = 0;
      end
      if (!start_high) begin
         start <= 1'b1;
         start_high = 1;
      end
      req_func       <= f;
      req_pos_x      <= px;
      req_pos_y      <= py;
      req_glyph      <= g;
      req_color_word <= c;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_fb_beats(f, px, py, g, c);
      if (fixed)
         pending_beats.push_back(want);
      else
         foreach (cmd_beats[k]) pending_beats.push_back(cmd_beats[k]);
   endtask

   // ------------------------------------------------------- directed script
   function automatic script_row_t cmd(func_type f, int x, int y, int g, int c);
      script_row_t r;
      r.is_write = 1'b0;
      r.idx      = CSR_BG_CHAR;
      r.wdata    = '0;
      r.func     = f;
      r.px       = POS_W'(x);
      r.py       = POS_W'(y);
      r.glyph    = CHAR_W'(g);
      r.color    = COLOR_W'(c);
      r.fixed    = 1'b0;
      r.want     = '0;
      return r;
   endfunction

   function automatic script_row_t cmd_fixed(func_type f, int x, int y, int g, int c,
                                             fb_beat_t w);
      script_row_t r;
      r       = cmd(f, x, y, g, c);
      r.fixed = 1'b1;
      r.want  = w;
      return r;
   endfunction

   function automatic script_row_t reg_write(csr_index_type idx, int d);
      script_row_t r;
      r          = cmd(FUNC_DRAW, 0, 0, 0, 0);
      r.is_write = 1'b1;
      r.idx      = idx;
      r.wdata    = CSR_DATA_W'(d);
      return r;
   endfunction

   // ----------------------------------------------------------------- main
   initial begin
      script_row_t             script [$];
      fb_beat_t                draw_ok, draw_bad, end_mark;
      func_type                f;
      logic [POS_W-1:0]        px, py;
      logic [CHAR_W-1:0]       bgc;
      logic [COLOR_W-1:0]      bgw, junk;
      logic [WIDTH_REG_W-1:0]  w;
      logic [HEIGHT_REG_W-1:0] h;
      logic                    m;
      int                      n, pick, cols, rows;

      draw_ok  = make_beat(KIND_DRAW, STATUS_OK,  0, 0, '0, '0, 1'b1);
      draw_bad = make_beat(KIND_DRAW, STATUS_BAD, 0, 0, '0, '0, 1'b1);
      end_mark = make_beat(KIND_END,  STATUS_OK,  0, 0, '0, '0, 1'b1);

      // Opening forced clear at full size writes every cell, so no later
      // plain clear ever compares a cell that was never written.
      script.push_back(cmd_fixed(FUNC_FORCE, 0, 0, 0, 0, end_mark));
      // corners and every way a draw can miss the area
      script.push_back(cmd_fixed(FUNC_DRAW, 0, 0, 8'h00, 16'h0000, draw_ok));
      script.push_back(cmd_fixed(FUNC_DRAW, 63, 63, 8'hff, 16'hffff, draw_ok));
      script.push_back(cmd_fixed(FUNC_DRAW, -1, 0, 8'h11, 16'h1111, draw_bad));
      script.push_back(cmd_fixed(FUNC_DRAW, -512, 511, 8'h22, 16'h2222, draw_bad));
      script.push_back(cmd_fixed(FUNC_DRAW, 64, 0, 8'h33, 16'h3333, draw_bad));
      script.push_back(cmd_fixed(FUNC_DRAW, 0, 64, 8'h44, 16'h4444, draw_bad));
      script.push_back(cmd_fixed(FUNC_DRAW, 511, -512, 8'h55, 16'h5555, draw_bad));
      script.push_back(cmd_fixed(FUNC_DRAW, 5, 0, 8'h41, 16'h00ff, draw_ok));
      // whole row marked by the forced clear: 64 beats
      script.push_back(cmd(FUNC_FLUSH, 0, 0, 0, 0));
      script.push_back(cmd_fixed(FUNC_FLUSH, 0, 0, 0, 0, end_mark));
      script.push_back(cmd_fixed(FUNC_FLUSH, 0, -1, 0, 0, end_mark));
      script.push_back(cmd_fixed(FUNC_FLUSH, 0, 64, 0, 0, end_mark));
      script.push_back(cmd_fixed(FUNC_DRAW, 7, 1, 8'h55, 16'ha5a5, draw_ok));
      // plain clear: only the drawn cells come back marked
      script.push_back(cmd_fixed(FUNC_CLEAR, 0, 0, 0, 0, end_mark));
      script.push_back(cmd(FUNC_FLUSH, 0, 63, 0, 0));
      script.push_back(cmd(FUNC_FLUSH, 0, 1, 0, 0));
      // muted flush still drops the mark
      script.push_back(reg_write(CSR_MUTE, 1));
      script.push_back(cmd_fixed(FUNC_DRAW, 3, 1, 8'h07, 16'h1234, draw_ok));
      script.push_back(cmd_fixed(FUNC_FLUSH, 0, 1, 0, 0, end_mark));
      script.push_back(reg_write(CSR_MUTE, 0));
      script.push_back(cmd_fixed(FUNC_FLUSH, 0, 1, 0, 0, end_mark));
      // zero width: nothing in use
      script.push_back(reg_write(CSR_WIDTH, 0));
      script.push_back(cmd_fixed(FUNC_DRAW, 0, 0, 8'h01, 16'h0101, draw_bad));
      script.push_back(cmd_fixed(FUNC_CLEAR, 0, 0, 0, 0, end_mark));
      // oversized sizes saturate; top background values
      script.push_back(reg_write(CSR_WIDTH, 16'hff7f));
      script.push_back(reg_write(CSR_HEIGHT, 16'h01ff));
      script.push_back(reg_write(CSR_BG_CHAR, 16'h00ff));
      script.push_back(reg_write(CSR_BG_COLOR, 16'hffff));
      script.push_back(cmd_fixed(FUNC_FORCE, 0, 0, 0, 0, end_mark));
      script.push_back(cmd(FUNC_FLUSH, 0, 63, 0, 0));
      script.push_back(cmd_fixed(FUNC_DRAW, 63, 63, 8'h80, 16'h8001, draw_ok));
      script.push_back(cmd_fixed(FUNC_DRAW, 0, 64, 8'h80, 16'h8001, draw_bad));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].is_write) begin
            write_reg(script[k].idx, script[k].wdata);
         end else begin
            sender_gap();
            issue_command(script[k].func, script[k].px, script[k].py, script[k].glyph,
                          script[k].color, script[k].fixed, script[k].want);
         end
      end

      // Random phases, each with its own register setting. Mostly small
      // areas; the full-size phase skips clears to keep the run short.
      for (int p = 0; p < PHASES; p++) begin
         bgc = 8'($urandom);
         bgw = 16'($urandom);
         m   = 1'b0;
         n   = 24;
         case (p)
            0: begin
               bgc = 8'h20;
               w   = 7'($urandom_range(1, 8));
               h   = 9'($urandom_range(1, 8));
            end
            1: begin
               bgc = 8'h00;
               bgw = 16'h0000;
               w   = 7'd1;
               h   = 9'd1;
               n   = 14;
            end
            2: begin
               w = 7'd64;
               h = 9'd256;
            end
            3: begin
               w = 7'($urandom_range(3, 10));
               h = 9'($urandom_range(2, 5));
               m = 1'b1;
            end
            4: begin
               w = 7'($urandom_range(1, 16));
               h = 9'($urandom_range(1, 4));
            end
            5: begin
               bgc = 8'hff;
               bgw = 16'hffff;
               w   = 7'($urandom_range(2, 12));
               h   = 9'($urandom_range(2, 12));
            end
            default: begin
               // zero height
               w = 7'd5;
               h = 9'd0;
               m = 1'($urandom);
               n = 12;
            end
         endcase
         // unused upper data bits carry junk half the time
         junk = $urandom_range(0, 1) ? 16'($urandom) : 16'h0000;
         write_reg(CSR_BG_CHAR,  {junk[15:8], bgc});
         write_reg(CSR_BG_COLOR, bgw);
         write_reg(CSR_WIDTH,    {junk[15:7], w});
         write_reg(CSR_HEIGHT,   {junk[15:9], h});
         write_reg(CSR_MUTE,     {junk[15:1], m});

         idling_on = (p != 4);   // one phase runs back to back
         for (int k = 0; k < n; k++) begin
            sender_gap();
            cols = cols_in_use();
            rows = rows_in_use();
            pick = $urandom_range(0, 99);
            if (pick < 50)      f = FUNC_DRAW;
            else if (pick < 80) f = FUNC_FLUSH;
            else if (pick < 90) f = FUNC_CLEAR;
            else                f = FUNC_FORCE;
            if ((f == FUNC_CLEAR || f == FUNC_FORCE) && cols * rows > 256) f = FUNC_FLUSH;
            // mostly inside the area, the rest anywhere in the 10-bit range
            px = (cols > 0 && $urandom_range(0, 4) != 0) ?
                 POS_W'($urandom_range(0, cols - 1)) : POS_W'($urandom);
            py = (rows > 0 && $urandom_range(0, 4) != 0) ?
                 POS_W'($urandom_range(0, rows - 1)) : POS_W'($urandom);
            issue_command(f, px, py, CHAR_W'($urandom), COLOR_W'($urandom), 1'b0, '0);
            // hold off once until the block has caught up
            if (p == 3 && k == n / 2) drain();
         end
      end

      drain();
      // stray beats after the last one would still be caught here
      repeat (FB_COLS) @(posedge clock);
      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
